// File: rtl/rpt_pkg.sv
// shared types, widths and codes for the repeating pulse timer
// no dependencies; imported by every rtl file of the block
package rpt_pkg;

   // width of the elapsed-time accumulator and of the pulse counter
   localparam int TIME_WIDTH  = 32;
   localparam int COUNT_WIDTH = 16;

   // fixed widths of the item fields and configuration registers
   localparam int FIELD_TIME_W = 32;
   localparam int FIELD_MAX_W  = 16;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;

   // compare widths wide enough for both operands
   localparam int CMP_W     = (TIME_WIDTH > FIELD_TIME_W) ? TIME_WIDTH : FIELD_TIME_W;
   localparam int CNT_CMP_W = (COUNT_WIDTH > FIELD_MAX_W) ? COUNT_WIDTH : FIELD_MAX_W;

   localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_RESTART = 2'd1,
      CMD_STOP    = 2'd2
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FIRST_DELAY      = 3'd0,
      REG_PULSE_TIME       = 3'd1,
      REG_SLEEP_DELAY      = 3'd2,
      REG_MAX_PULSES       = 3'd3,
      REG_TICK_WHEN_PAUSED = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [1:0]              cmd;
      logic [FIELD_TIME_W-1:0] time_step;
      logic                    local_pause;
      logic                    global_pause;
   } req_item_type;

   typedef struct packed {
      logic [1:0] trigger_count;
      logic       is_finished;
      logic       is_pulsing;
   } rsp_item_type;

   typedef struct packed {
      logic [FIELD_TIME_W-1:0] first_delay;
      logic [FIELD_TIME_W-1:0] pulse_time;
      logic [FIELD_TIME_W-1:0] sleep_delay;
      logic [FIELD_MAX_W-1:0]  max_pulses;
      logic                    tick_when_paused;
   } cfg_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0]  elapsed;
      logic [COUNT_WIDTH-1:0] pulse_count;
      logic                   finished;
      logic                   pulsing;
      logic                   first_done;
   } timer_state_type;

endpackage

// File: rtl/rpt_cfg_regs.sv
// configuration register file of the repeating pulse timer
// depends on rpt_pkg
module rpt_cfg_regs
   import rpt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_FIRST_DELAY:      cfg_in.first_delay      = csr_wdata[FIELD_TIME_W-1:0];
            REG_PULSE_TIME:       cfg_in.pulse_time       = csr_wdata[FIELD_TIME_W-1:0];
            REG_SLEEP_DELAY:      cfg_in.sleep_delay      = csr_wdata[FIELD_TIME_W-1:0];
            REG_MAX_PULSES:       cfg_in.max_pulses       = csr_wdata[FIELD_MAX_W-1:0];
            REG_TICK_WHEN_PAUSED: cfg_in.tick_when_paused = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/rpt_step.sv
// next-state and result logic for one item of the repeating pulse timer
// depends on rpt_pkg
module rpt_step
   import rpt_pkg::*;
(
   input  cfg_type         cfg,
   input  timer_state_type state_cur,
   input  req_item_type    item,
   output timer_state_type state_nxt,
   output rsp_item_type    result
);

   function automatic logic at_least(input logic [TIME_WIDTH-1:0] a,
                                     input logic [FIELD_TIME_W-1:0] b);
      return CMP_W'(a) >= CMP_W'(b);
   endfunction

   function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] a,
                                                      input logic [FIELD_TIME_W-1:0] b);
      logic [CMP_W:0] sum;
      sum = (CMP_W+1)'(a) + (CMP_W+1)'(b);
      if (sum > (CMP_W+1)'(TIME_MAX)) begin
         return TIME_MAX;
      end
      return sum[TIME_WIDTH-1:0];
   endfunction

   function automatic logic limit_hit(input logic [COUNT_WIDTH-1:0] cnt,
                                      input logic [FIELD_MAX_W-1:0] maxp);
      return (maxp != '0) && (CNT_CMP_W'(cnt) == CNT_CMP_W'(maxp));
   endfunction

   logic [TIME_WIDTH-1:0]  el;
   logic [COUNT_WIDTH-1:0] cnt;
   logic                   fin;
   logic                   pls;
   logic                   first;
   logic [1:0]             fired;
   logic                   stop;
   logic                   run_tick;

   assign run_tick = !state_cur.finished && !item.local_pause
                     && !(item.global_pause && !cfg.tick_when_paused);

   always_comb begin
      el    = state_cur.elapsed;
      cnt   = state_cur.pulse_count;
      fin   = state_cur.finished;
      pls   = state_cur.pulsing;
      first = state_cur.first_done;
      fired = 2'd0;
      stop  = 1'b0;
      case (cmd_type'(item.cmd))
         CMD_TICK: begin
            if (run_tick) begin
               // inside the pulse window
               if (pls) begin
                  if (at_least(el, cfg.pulse_time)) begin
                     el = '0;
                     if (limit_hit(cnt, cfg.max_pulses)) begin
                        fin = 1'b1; pls = 1'b0; first = 1'b0; stop = 1'b1;
                     end else begin
                        pls = 1'b0;
                     end
                  end else begin
                     fired = fired + 2'd1;
                     el    = sat_add(el, item.time_step);
                     stop  = 1'b1;
                  end
               end
               // waiting for the first delay
               if (!stop && !first) begin
                  if (at_least(el, cfg.first_delay)) begin
                     first = 1'b1;
                     pls   = 1'b1;
                     cnt   = cnt + COUNT_WIDTH'(1);
                     fired = fired + 2'd1;
                     el    = '0;
                     if (cfg.pulse_time == '0) begin
                        if (limit_hit(cnt, cfg.max_pulses)) begin
                           fin = 1'b1; pls = 1'b0; first = 1'b0; stop = 1'b1;
                        end else begin
                           pls = 1'b0;
                        end
                     end
                  end else begin
                     el   = sat_add(el, item.time_step);
                     stop = 1'b1;
                  end
               end
               // sleeping between pulses
               if (!stop) begin
                  if (at_least(el, cfg.sleep_delay)) begin
                     pls   = 1'b1;
                     cnt   = cnt + COUNT_WIDTH'(1);
                     fired = fired + 2'd1;
                     el    = '0;
                     if (limit_hit(cnt, cfg.max_pulses)) begin
                        fin = 1'b1; pls = 1'b0; first = 1'b0; stop = 1'b1;
                     end else if (cfg.pulse_time == '0) begin
                        pls = 1'b0;
                     end
                  end
                  if (!stop) begin
                     el = sat_add(el, item.time_step);
                  end
               end
            end
         end
         CMD_RESTART: begin
            el = '0; cnt = '0; fin = 1'b0; pls = 1'b0; first = 1'b0;
         end
         CMD_STOP: begin
            fin = 1'b1; pls = 1'b0; first = 1'b0;
         end
         default: ;
      endcase
   end

   assign state_nxt.elapsed     = el;
   assign state_nxt.pulse_count = cnt;
   assign state_nxt.finished    = fin;
   assign state_nxt.pulsing     = pls;
   assign state_nxt.first_done  = first;

   assign result.trigger_count = fired;
   assign result.is_finished   = fin;
   assign result.is_pulsing    = pls;

endmodule

// File: rtl/repeating_pulse_timer_top.sv
// repeating pulse timer: an accepted item passes the input register, then
// the step logic into the result register; throughput one item per clock
// while the result output does not stall; the step logic (three compares, a
// saturating add and a counter increment) is one registered pass
// synchronous active-high reset clears the pipeline valids, the timer state
// and all configuration registers to zero
module repeating_pulse_timer_top
   import rpt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // item input
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_item_type           req_item,
   // result output
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_item_type           rsp_item,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type         cfg;

   // input register stage
   logic            s1_valid_ff;
   logic            s1_valid_in;
   req_item_type    s1_item_ff;

   // result register stage
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_item_type    rsp_item_ff;

   // timer state, updated when an item leaves the input register
   timer_state_type state_ff;
   timer_state_type state_nxt;
   rsp_item_type    step_result;

   logic            out_free;
   logic            s1_move;
   logic            req_take;

   rpt_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rpt_step u_step (
      .cfg       (cfg),
      .state_cur (state_ff),
      .item      (s1_item_ff),
      .state_nxt (state_nxt),
      .result    (step_result)
   );

   // result register can take a new item when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;
   // input item advances into the result register
   assign s1_move  = s1_valid_ff && out_free;
   // input register stalls only when it holds an item that cannot move
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_move) begin
            state_ff <= state_nxt;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_item;
      end
      if (s1_move) begin
         rsp_item_ff <= step_result;
      end
   end

   // at most two triggers per item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_item_ff.trigger_count != 2'd3))
      else $error("trigger count out of range");

   // a finished timer is never pulsing and has no first-delay mark
   assert property (@(posedge clock) disable iff (reset)
      state_ff.finished |-> (!state_ff.pulsing && !state_ff.first_done))
      else $error("finished timer carries active flags");

   // reported flags follow the timer state just written
   assert property (@(posedge clock) disable iff (reset)
      s1_move |=> (rsp_valid_ff && rsp_item_ff.is_finished == state_ff.finished
                   && rsp_item_ff.is_pulsing == state_ff.pulsing))
      else $error("result flags disagree with timer state");

   // an item in the input register is never overwritten before it moves
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> (s1_valid_ff && $stable(s1_item_ff)))
      else $error("input register lost an item");

endmodule
